/* src/array_list_engine_defines.svh */
// Assertion shorthands, clocked on i_clk and quiet while i_rst_n is low.
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define ALE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ale_pkg.sv */
package ale_pkg;

    localparam int KEY_W   = 16;
    localparam int SCORE_W = 10;
    localparam int CAP_W   = 5;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int FIDX_W  = 4;
    localparam int CNTO_W  = 5;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_BACK  = 3'd4;
    localparam logic [2:0] OP_RD_FRONT  = 3'd5;
    localparam logic [2:0] OP_SEARCH    = 3'd6;
    localparam logic [2:0] OP_CLEAR     = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } t_rec;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SHR  = 5'b00010,
        S_SHL  = 5'b00100,
        S_SRCH = 5'b01000,
        S_RDF  = 5'b10000
    } t_state;

endpackage

/* src/ale_ram.sv */
module ale_ram
    import ale_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rec          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/array_list_engine.sv */
// Ordered list of (key, score) records held in one record RAM.
// Command: pulse i_start with i_op and the operands while o_busy is low; the
// word is taken at that edge. Exactly one result word follows, shown for one
// cycle with o_done high; the receiver cannot hold it off.
// Configuration: i_cfg_we writes i_cfg_wdata to the capacity register; write
// only while no command is in flight.
// Work from accept to o_done, with n the entry count before the command:
//   rejected commands, delete back, clear: done without a RAM walk
//   insert at slot a (zero-based): entries a..n-1 shift up one per cycle
//   delete front: a lone entry goes at once, else the rest shift down
//   read front: reads entry 0; search: walks up to a match or the end
// Shifts and search walk the RAM one entry per cycle through its single read
// and single write port; a new command is taken in the cycle o_done is high.
// Reset empties the list and sets the capacity to 16; RAM contents are not
// cleared since only entries below the count are ever read.
`include "array_list_engine_defines.svh"

module array_list_engine
    import ale_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_op,
    input  logic [KEY_W-1:0]   i_roll_no,
    input  logic [SCORE_W-1:0] i_score,
    input  logic [POS_W-1:0]   i_position,
    input  logic [KEY_W-1:0]   i_search_key,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_wdata,
    output logic               o_done,
    output logic [STAT_W-1:0]  o_status,
    output logic [FIDX_W-1:0]  o_found_index,
    output logic [KEY_W-1:0]   o_found_roll_no,
    output logic [SCORE_W-1:0] o_found_score,
    output logic [CNTO_W-1:0]  o_entry_count,
    output logic               o_is_full,
    output logic               o_is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > CAP_W) ? CW : CAP_W;
    localparam int PW = KW + 1;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CAP_W-1:0]    r_cap;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_at, n_at;
    t_rec                r_rec, n_rec;
    logic [KEY_W-1:0]    r_skey, n_skey;
    logic                r_done, n_done;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [FIDX_W-1:0]   r_fidx, n_fidx;
    logic [KEY_W-1:0]    r_froll, n_froll;
    logic [SCORE_W-1:0]  r_fscore, n_fscore;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    t_rec                ram_wdata, ram_rdata;

    logic [KW-1:0]       eff_cap;
    logic                full, empty, bad_pos, accept;
    logic [AW-1:0]       ins_at;

    ale_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign eff_cap = (KW'(r_cap) < KW'(DEPTH)) ? KW'(r_cap) : KW'(DEPTH);
    assign full    = KW'(r_count) >= eff_cap;
    assign empty   = (r_count == '0);
    assign bad_pos = (i_position == '0) || (PW'(i_position) > PW'(r_count) + PW'(1));
    assign accept  = i_start && (r_state == S_IDLE);

    always_comb begin
        case (i_op)
            OP_INS_FRONT: ins_at = '0;
            OP_INS_BACK:  ins_at = AW'(r_count);
            default:      ins_at = AW'(i_position - POS_W'(1));
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_at      = r_at;
        n_rec     = r_rec;
        n_skey    = r_skey;
        n_done    = 1'b0;
        n_status  = r_status;
        n_fidx    = r_fidx;
        n_froll   = r_froll;
        n_fscore  = r_fscore;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rec    = '{key: i_roll_no, score: i_score};
                    n_skey   = i_search_key;
                    n_status = ST_OK;
                    n_fidx   = '0;
                    n_froll  = '0;
                    n_fscore = '0;
                    case (i_op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                            if (full) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else if (i_op == OP_INS_POS && bad_pos) begin
                                n_status = ST_BADPOS;
                                n_done   = 1'b1;
                            end else begin
                                n_at    = ins_at;
                                n_idx   = AW'(r_count);
                                n_state = S_SHR;
                                // fetch the last entry unless appending
                                if (CW'(ins_at) != r_count) begin
                                    ram_re    = 1'b1;
                                    ram_raddr = AW'(r_count - CW'(1));
                                end
                            end
                        end
                        OP_DEL_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else if (r_count == CW'(1)) begin
                                n_count = '0;
                                n_done  = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(1);
                                n_idx     = '0;
                                n_state   = S_SHL;
                            end
                        end
                        OP_DEL_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                            n_done = 1'b1;
                        end
                        OP_RD_FRONT, OP_SEARCH: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_state   = (i_op == OP_SEARCH) ? S_SRCH : S_RDF;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                    endcase
                end
            end
            S_SHR: begin
                ram_we = 1'b1;
                if (r_idx == r_at) begin
                    // slot is open: drop the new record in
                    ram_waddr = r_at;
                    ram_wdata = r_rec;
                    n_count   = r_count + CW'(1);
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    ram_waddr = r_idx;
                    if (CW'(r_idx) > CW'(r_at) + CW'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx - AW'(2);
                    end
                    n_idx = r_idx - AW'(1);
                end
            end
            S_SHL: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                if (CW'(r_idx) + CW'(2) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + AW'(2);
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_SRCH: begin
                if (ram_rdata.key == r_skey) begin
                    n_status = ST_OK;
                    n_fidx   = FIDX_W'(r_idx);
                    n_froll  = ram_rdata.key;
                    n_fscore = ram_rdata.score;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_status = ST_NOTFOUND;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_RDF: begin
                n_froll  = ram_rdata.key;
                n_fscore = ram_rdata.score;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_at     <= n_at;
        r_rec    <= n_rec;
        r_skey   <= n_skey;
        r_status <= n_status;
        r_fidx   <= n_fidx;
        r_froll  <= n_froll;
        r_fscore <= n_fscore;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found_index   = r_fidx;
    assign o_found_roll_no = r_froll;
    assign o_found_score   = r_fscore;
    assign o_entry_count   = CNTO_W'(r_count);
    assign o_is_full       = full;
    assign o_is_empty      = empty;

    `ALE_ASSERT_NOW(a_done_idle, r_done, r_state == S_IDLE, "result word while still walking")
    `ALE_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(DEPTH), "entry count beyond depth")
    `ALE_ASSERT_NOW(a_shr_bound, r_state == S_SHR, r_idx >= r_at, "shift ran past insert slot")
    `ALE_ASSERT_NOW(a_count_on_done, !$stable(r_count), r_done, "count moved without a result")
    `ALE_ASSERT_NOW(a_walk_no_cmd, r_state != S_IDLE, !(accept), "command taken while busy")

endmodule
